FILE: hw/rtl/ilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilt_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_PREFIX,
    PH_CMD,
    PH_TEXT,
    PH_PARAM,
    PH_TOPIC
  } phase_t;

  // Byte tags
  localparam logic [3:0] TAG_COLON   = 4'd0;
  localparam logic [3:0] TAG_SEP     = 4'd1;
  localparam logic [3:0] TAG_NICK    = 4'd2;
  localparam logic [3:0] TAG_USER    = 4'd3;
  localparam logic [3:0] TAG_HOST    = 4'd4;
  localparam logic [3:0] TAG_COMMAND = 4'd5;
  localparam logic [3:0] TAG_TARGET  = 4'd6;
  localparam logic [3:0] TAG_TEXT    = 4'd7;
  localparam logic [3:0] TAG_PARAM   = 4'd8;
  localparam logic [3:0] TAG_SKIP    = 4'd9;

  // Command classes
  localparam logic [2:0] CLS_PRIVMSG = 3'd0;
  localparam logic [2:0] CLS_NOTICE  = 3'd1;
  localparam logic [2:0] CLS_NICK    = 3'd2;
  localparam logic [2:0] CLS_PING    = 3'd3;
  localparam logic [2:0] CLS_JOIN    = 3'd4;
  localparam logic [2:0] CLS_PART    = 3'd5;
  localparam logic [2:0] CLS_TOPIC   = 3'd6;
  localparam logic [2:0] CLS_OTHER   = 3'd7;

  localparam int NAME_COUNT = 7;

  localparam logic [7:0] CMD_NAME [NAME_COUNT][8] = '{
    '{"P", "R", "I", "V", "M", "S", "G", 8'h00},
    '{"N", "O", "T", "I", "C", "E", 8'h00, 8'h00},
    '{"N", "I", "C", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "A", "R", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", "O", "P", "I", "C", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] CMD_LEN [NAME_COUNT] = '{
    4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5
  };

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  marks;        // bit 0 '!' seen, bit 1 '@' seen
    logic        colon_seen;
    logic [1:0]  skip_count;
    logic [3:0]  cmd_len;
    logic [6:0]  match;
    logic [31:0] crc;
    logic [15:0] acc;          // magnitude, saturates at 32768
    logic        num_started;
    logic        num_neg;
    logic        num_stopped;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_START,
    marks:       2'b00,
    colon_seen:  1'b0,
    skip_count:  2'd0,
    cmd_len:     4'd0,
    match:       7'h7F,
    crc:         32'hFFFF_FFFF,
    acc:         16'd0,
    num_started: 1'b0,
    num_neg:     1'b0,
    num_stopped: 1'b0
  };

  typedef struct packed {
    logic               parse_status;
    logic               prefix_split;
    logic signed [15:0] reply_number;
    logic               is_numeric;
    logic [31:0]        command_crc;
    logic [2:0]         command_class;
    logic               line_done;
    logic [3:0]         byte_tag;
  } result_t;

  function automatic logic [7:0] upcase(input logic [7:0] b);
    return (b >= "a" && b <= "z") ? b - 8'd32 : b;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // First name still matching whose length equals the command length.
  function automatic logic [2:0] cmd_class(input logic [6:0] match, input logic [3:0] len);
    logic [2:0] c;
    logic       found;
    c = CLS_OTHER;
    found = 1'b0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (!found && match[i] && len == CMD_LEN[i]) begin
        c = 3'(i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/irc_line_tokenizer.sv
// Channel  Direction  Beat contents
// s_axis   in         tdata[7:0] line_byte, tlast end_of_line
// m_axis   out        tdata byte_tag..parse_status (see port), tlast line_done
//
// One byte per cycle sustained while the output is not stalled by m_axis_tready.
// A byte waits in the input register, then the tokenizer state and CRC update
// in one pass while the result is written to the output register.
// While a result is stalled one more byte is taken into the input register.
// Reset (rst, synchronous) empties both registers and returns to start of line.
`timescale 1ns / 1ps
`default_nettype none

module irc_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [3:0] byte_tag, [6:4] command_class,
                                      // [38:7] command_crc, [39] is_numeric,
                                      // [55:40] reply_number, [56] prefix_split,
                                      // [57] parse_status, [63:58] zero
  output logic        m_axis_tlast
);
  import ilt_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  result_t    out_res;
  state_t     state;
  state_t     state_next;
  result_t    res_next;
  logic       advance;
  logic       step;

  assign advance       = !out_valid || m_axis_tready;
  assign step          = advance && in_valid;
  assign s_axis_tready = !in_valid || advance;

  ilt_step u_step (
    .cur         (state),
    .line_byte   (in_byte),
    .end_of_line (in_last),
    .nxt         (state_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (step) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (step) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.line_done;
  assign m_axis_tdata  = {6'd0, out_res.parse_status, out_res.prefix_split,
                          out_res.reply_number, out_res.is_numeric,
                          out_res.command_crc, out_res.command_class,
                          out_res.byte_tag};

  // Summary fields stay clear on every beat that does not end a line.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[57:4] == 54'd0))
    else $error("summary fields set before end of line");

  // A reply number is only reported together with its numeric flag.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[55:40] != 16'd0) |-> m_axis_tdata[39])
    else $error("reply number without numeric flag");

  // After the last byte of a line is processed the parser is back at line start.
  assert property (@(posedge clk) disable iff (rst)
    (step && in_last) |=> (state == STATE_RESET))
    else $error("state not cleared after end of line");

  // A line that never left prefix or command phase reports as malformed.
  assert property (@(posedge clk) disable iff (rst)
    (step && in_last && (state.phase == PH_PREFIX || state.phase == PH_CMD) &&
     (in_byte != CH_SPACE)) |=> out_res.parse_status)
    else $error("unterminated command not flagged");

endmodule

`default_nettype wire

FILE: hw/rtl/ilt_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ilt_step (
  input  ilt_pkg::state_t  cur,
  input  logic [7:0]       line_byte,
  input  logic             end_of_line,
  output ilt_pkg::state_t  nxt,
  output ilt_pkg::result_t res
);
  import ilt_pkg::*;

  state_t      st;
  logic [3:0]  tag;
  logic        cmd_path;
  logic        is_space;
  logic [2:0]  cls_now;
  logic [6:0]  match_upd;
  logic [7:0]  ub;
  logic        is_digit;
  logic        is_ws;
  logic [3:0]  digit;
  logic [18:0] acc_mul;
  logic [2:0]  cls_end;
  logic [15:0] value;

  assign is_space = (line_byte == CH_SPACE);
  assign ub       = upcase(line_byte);
  assign cls_now  = cmd_class(cur.match, cur.cmd_len);
  assign is_digit = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
  assign is_ws    = (line_byte >= CH_TAB) && (line_byte <= CH_CR);
  assign digit    = 4'(line_byte - CH_ZERO);
  assign acc_mul  = ({3'd0, cur.acc} << 3) + ({3'd0, cur.acc} << 1) + 19'(digit);

  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      match_upd[i] = cur.match[i] && (cur.cmd_len < CMD_LEN[i]) &&
                     (ub == CMD_NAME[i][cur.cmd_len[2:0]]);
    end
  end

  always_comb begin
    st       = cur;
    tag      = TAG_PARAM;
    cmd_path = 1'b0;

    unique case (cur.phase)
      PH_START: begin
        if (line_byte == CH_COLON) begin
          tag      = TAG_COLON;
          st.phase = PH_PREFIX;
        end else begin
          cmd_path = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (is_space) begin
          tag      = TAG_SEP;
          st.phase = PH_CMD;
        end else if (!cur.marks[0]) begin
          if (line_byte == CH_BANG) begin
            st.marks[0] = 1'b1;
            tag         = TAG_SEP;
          end else begin
            tag = TAG_NICK;
          end
        end else if (!cur.marks[1]) begin
          if (line_byte == CH_AT) begin
            st.marks[1] = 1'b1;
            tag         = TAG_SEP;
          end else begin
            tag = TAG_USER;
          end
        end else begin
          tag = TAG_HOST;
        end
      end
      PH_CMD: cmd_path = 1'b1;
      PH_TEXT: begin
        if (cur.colon_seen) begin
          tag = TAG_TEXT;
        end else if (line_byte == CH_COLON) begin
          st.colon_seen = 1'b1;
          tag           = TAG_SEP;
        end else begin
          tag = TAG_TARGET;
        end
      end
      PH_TOPIC: begin
        if (cur.skip_count == 2'd0) begin
          if (is_space) begin
            st.skip_count = 2'd1;
            tag           = TAG_SEP;
          end else begin
            tag = TAG_TARGET;
          end
        end else if (cur.skip_count == 2'd1) begin
          st.skip_count = 2'd2;
          tag           = TAG_SKIP;
        end else begin
          tag = TAG_TEXT;
        end
      end
      default: tag = TAG_PARAM;
    endcase

    if (cmd_path) begin
      if (is_space) begin
        tag = TAG_SEP;
        if (cls_now == CLS_PRIVMSG || cls_now == CLS_NOTICE || cls_now == CLS_PART) begin
          st.phase = PH_TEXT;
        end else if (cls_now == CLS_TOPIC) begin
          st.phase = PH_TOPIC;
        end else begin
          st.phase = PH_PARAM;
        end
      end else begin
        tag      = TAG_COMMAND;
        st.phase = PH_CMD;
        st.match = match_upd;
        if (cur.cmd_len != 4'd15) begin
          st.cmd_len = cur.cmd_len + 4'd1;
        end
        st.crc = crc_byte(cur.crc, line_byte);
        // atoi-style scan: white space, one sign, then digits until anything else.
        if (!cur.num_stopped) begin
          if (is_digit) begin
            st.acc         = (acc_mul > 19'd32768) ? 16'd32768 : acc_mul[15:0];
            st.num_started = 1'b1;
          end else if (!cur.num_started && (line_byte == CH_PLUS ||
                                            line_byte == CH_MINUS)) begin
            st.num_started = 1'b1;
            st.num_neg     = (line_byte == CH_MINUS);
          end else if (!cur.num_started && is_ws) begin
            st.num_stopped = 1'b0;
          end else begin
            st.num_stopped = 1'b1;
          end
        end
      end
    end
  end

  assign cls_end = cmd_class(st.match, st.cmd_len);
  assign value   = st.num_neg ? 16'(16'd0 - st.acc) :
                   (st.acc[15] ? 16'h7FFF : st.acc);

  always_comb begin
    res          = '0;
    res.byte_tag = tag;
    nxt          = st;
    if (end_of_line) begin
      res.line_done = 1'b1;
      nxt           = STATE_RESET;
      if (st.phase == PH_PREFIX || st.phase == PH_CMD || st.phase == PH_START) begin
        // The command was never closed by a space.
        res.command_class = CLS_OTHER;
        res.parse_status  = 1'b1;
      end else begin
        res.command_class = cls_end;
        res.command_crc   = ~st.crc;
        if (cls_end == CLS_OTHER && value != 16'd0) begin
          res.is_numeric   = 1'b1;
          res.reply_number = value;
        end
        res.prefix_split = st.marks[0];
        res.parse_status = (cls_end == CLS_PRIVMSG || cls_end == CLS_NOTICE) &&
                           !st.colon_seen;
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ilt_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int PHASE_BYTES = 340;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [3:0]         tag;
    logic               done;
    logic [2:0]         cls;
    logic [31:0]        crc;
    logic               numeric;
    logic signed [15:0] reply;
    logic               split;
    logic               status;
  } line_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  irc_line_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  line_beat_t   pending_beats[$];
  line_result_t expected_results[$];
  logic [7:0]   line_buf[$];

  int mismatch_count = 0;
  int result_count = 0;
  int queued_count = 0;
  int send_idle_pct = 30;
  int recv_idle_pct = 82;
  bit hold_wanted = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  // Tokenizer state as predicted by the testbench.
  phase_t      tok_phase;
  logic [1:0]  seen_marks;
  logic        text_colon;
  logic [1:0]  topic_skips;
  logic [3:0]  cmd_count;
  logic [6:0]  name_hits;
  logic [31:0] cmd_crc;
  logic [15:0] num_mag;
  logic        num_started;
  logic        num_neg;
  logic        num_stopped;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] word_of(input int i);
    case (i)
      0: return "PRIVMSG";
      1: return "NOTICE";
      2: return "NICK";
      3: return "PING";
      4: return "JOIN";
      5: return "PART";
      default: return "TOPIC";
    endcase
  endfunction

  function automatic int len_of(input int i);
    case (i)
      0: return 7;
      1: return 6;
      6: return 5;
      default: return 4;
    endcase
  endfunction

  task automatic clear_line_state();
    tok_phase = PH_START;
    seen_marks = 2'b00;
    text_colon = 1'b0;
    topic_skips = 2'd0;
    cmd_count = 4'd0;
    name_hits = 7'h7F;
    cmd_crc = 32'hFFFF_FFFF;
    num_mag = 16'd0;
    num_started = 1'b0;
    num_neg = 1'b0;
    num_stopped = 1'b0;
  endtask

  function automatic logic [2:0] matched_class();
    for (int i = 0; i < 7; i++) begin
      if (name_hits[i] && int'(cmd_count) == len_of(i)) return 3'(i);
    end
    return CLS_OTHER;
  endfunction

  task automatic take_command_char(input logic [7:0] b, output logic [3:0] tag);
    logic [7:0]  up;
    logic [63:0] w;
    logic [31:0] c;
    logic [2:0]  cls;
    int          m;
    int          n;
    if (b == CH_SPACE) begin
      cls = matched_class();
      if (cls == CLS_PRIVMSG || cls == CLS_NOTICE || cls == CLS_PART) tok_phase = PH_TEXT;
      else if (cls == CLS_TOPIC) tok_phase = PH_TOPIC;
      else tok_phase = PH_PARAM;
      tag = TAG_SEP;
    end else begin
      tok_phase = PH_CMD;
      up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
      for (int i = 0; i < 7; i++) begin
        n = len_of(i);
        w = word_of(i);
        if (int'(cmd_count) >= n || up != w[8 * (n - 1 - int'(cmd_count)) +: 8])
          name_hits[i] = 1'b0;
      end
      if (cmd_count != 4'd15) cmd_count = cmd_count + 4'd1;
      c = cmd_crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
      cmd_crc = c;
      if (!num_stopped) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          m = int'(num_mag) * 10 + int'(b) - int'(CH_ZERO);
          num_mag = (m > 32768) ? 16'd32768 : 16'(m);
          num_started = 1'b1;
        end else if (!num_started && (b == CH_PLUS || b == CH_MINUS)) begin
          num_started = 1'b1;
          if (b == CH_MINUS) num_neg = 1'b1;
        end else if (!num_started && (b == CH_TAB || b == CH_LF || b == CH_VT ||
                                      b == CH_FF || b == CH_CR)) begin
          // Leading white space leaves the number untouched.
        end else begin
          num_stopped = 1'b1;
        end
      end
      tag = TAG_COMMAND;
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic eol);
    line_result_t r;
    logic [2:0]   cls;
    logic [15:0]  value;
    logic [3:0]   tag;
    r = '0;
    case (tok_phase)
      PH_START: begin
        if (b == CH_COLON) begin
          tag = TAG_COLON;
          tok_phase = PH_PREFIX;
        end else take_command_char(b, tag);
      end
      PH_PREFIX: begin
        if (b == CH_SPACE) begin
          tag = TAG_SEP;
          tok_phase = PH_CMD;
        end else if (!seen_marks[0]) begin
          if (b == CH_BANG) begin
            seen_marks[0] = 1'b1;
            tag = TAG_SEP;
          end else tag = TAG_NICK;
        end else if (!seen_marks[1]) begin
          if (b == CH_AT) begin
            seen_marks[1] = 1'b1;
            tag = TAG_SEP;
          end else tag = TAG_USER;
        end else tag = TAG_HOST;
      end
      PH_CMD: take_command_char(b, tag);
      PH_TEXT: begin
        if (text_colon) tag = TAG_TEXT;
        else if (b == CH_COLON) begin
          text_colon = 1'b1;
          tag = TAG_SEP;
        end else tag = TAG_TARGET;
      end
      PH_TOPIC: begin
        if (topic_skips == 2'd0) begin
          if (b == CH_SPACE) begin
            topic_skips = 2'd1;
            tag = TAG_SEP;
          end else tag = TAG_TARGET;
        end else if (topic_skips == 2'd1) begin
          topic_skips = 2'd2;
          tag = TAG_SKIP;
        end else tag = TAG_TEXT;
      end
      default: tag = TAG_PARAM;
    endcase
    r.tag = tag;
    if (eol) begin
      r.done = 1'b1;
      if (tok_phase == PH_START || tok_phase == PH_PREFIX || tok_phase == PH_CMD) begin
        // No space ever closed the command.
        r.cls = CLS_OTHER;
        r.status = 1'b1;
      end else begin
        cls = matched_class();
        if (num_neg) value = 16'd0 - num_mag;
        else value = (num_mag > 16'd32767) ? 16'd32767 : num_mag;
        r.cls = cls;
        r.crc = ~cmd_crc;
        if (cls == CLS_OTHER && value != 16'd0) begin
          r.numeric = 1'b1;
          r.reply = value;
        end
        r.split = seen_marks[0];
        r.status = (cls == CLS_PRIVMSG || cls == CLS_NOTICE) && !text_colon;
      end
      clear_line_state();
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    // Keep the log readable when everything goes wrong.
    if (mismatch_count <= 40)
      $display("result %0d: %s got %0h expected %0h", result_count, what, got, want);
  endtask

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin : driver
    line_beat_t nb;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) tokenize_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nb.ch;
          s_axis_tlast <= nb.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_wanted && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    line_result_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 64'd0);
      end else begin
        w = expected_results.pop_front();
        if (m_axis_tdata[3:0] !== w.tag) report_mismatch("byte_tag", m_axis_tdata[3:0], w.tag);
        if (m_axis_tlast !== w.done) report_mismatch("line_done", m_axis_tlast, w.done);
        if (m_axis_tdata[6:4] !== w.cls)
          report_mismatch("command_class", m_axis_tdata[6:4], w.cls);
        if (m_axis_tdata[38:7] !== w.crc)
          report_mismatch("command_crc", m_axis_tdata[38:7], w.crc);
        if (m_axis_tdata[39] !== w.numeric)
          report_mismatch("is_numeric", m_axis_tdata[39], w.numeric);
        if (m_axis_tdata[55:40] !== w.reply)
          report_mismatch("reply_number", m_axis_tdata[55:40], w.reply);
        if (m_axis_tdata[56] !== w.split)
          report_mismatch("prefix_split", m_axis_tdata[56], w.split);
        if (m_axis_tdata[57] !== w.status)
          report_mismatch("parse_status", m_axis_tdata[57], w.status);
      end
      result_count++;
    end
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  // Mostly letters, now and then any byte but a space.
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    if ($urandom_range(3) == 0) begin
      c = any_char();
      while (c == CH_SPACE) c = any_char();
    end else begin
      c = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
    end
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic add_word(input int n);
    repeat (n) line_buf.push_back(word_char());
  endtask

  task automatic add_any(input int n);
    repeat (n) line_buf.push_back(any_char());
  endtask

  // Moves the line into the beat queue; a cut line loses its tail.
  task automatic flush_line(input bit cut);
    int n;
    n = line_buf.size();
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) begin
      pending_beats.push_back('{ch: line_buf[i], last: (i == n - 1)});
      queued_count++;
    end
    line_buf.delete();
  endtask

  task automatic add_random_line();
    int          kind;
    int          n;
    logic [63:0] w;
    logic [7:0]  c;
    if ($urandom_range(7) == 0) begin
      add_any($urandom_range(1, 8));
      flush_line(1'b0);
    end else begin
      if ($urandom_range(1)) begin
        line_buf.push_back(CH_COLON);
        add_word($urandom_range(0, 4));
        if ($urandom_range(2) != 0) begin
          line_buf.push_back(CH_BANG);
          add_word($urandom_range(0, 4));
          if ($urandom_range(2) != 0) begin
            line_buf.push_back(CH_AT);
            add_word($urandom_range(0, 4));
          end
        end
        line_buf.push_back(CH_SPACE);
      end
      kind = $urandom_range(9);
      if (kind <= 6) begin
        n = len_of(kind);
        w = word_of(kind);
        for (int p = 0; p < n; p++) begin
          c = w[8 * (n - 1 - p) +: 8];
          if ($urandom_range(1)) c = c + 8'd32;
          if ($urandom_range(15) == 0) c = word_char();
          line_buf.push_back(c);
        end
        if ($urandom_range(9) == 0) add_word(1);
      end else if (kind == 7) begin
        repeat ($urandom_range(2)) line_buf.push_back(blank_char());
        n = $urandom_range(3);
        if (n == 0) line_buf.push_back(CH_PLUS);
        else if (n == 1) line_buf.push_back(CH_MINUS);
        n = ($urandom_range(3) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(3) == 0) add_word(1);
      end else if (kind == 8) begin
        add_word(($urandom_range(7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6));
      end
      if ($urandom_range(9) != 0) begin
        line_buf.push_back(CH_SPACE);
        if (kind == 0 || kind == 1 || kind == 5) begin
          add_word($urandom_range(0, 5));
          if ($urandom_range(3) != 0) begin
            line_buf.push_back(CH_COLON);
            add_any($urandom_range(0, 8));
          end
        end else if (kind == 6) begin
          add_word($urandom_range(0, 4));
          if ($urandom_range(3) != 0) begin
            line_buf.push_back(CH_SPACE);
            add_any($urandom_range(0, 8));
          end
        end else begin
          add_any($urandom_range(0, 8));
        end
      end
      flush_line($urandom_range(9) == 0);
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clear_line_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty command, line ending in the prefix, NOTICE without a colon,
    // saturated negative reply with a high byte, TOPIC ending at its space.
    add_text(" ");
    flush_line(1'b0);
    add_text(":a!b@c");
    flush_line(1'b0);
    add_text("NoTiCe x");
    flush_line(1'b0);
    add_text("-99999 ");
    line_buf.push_back(8'hFF);
    flush_line(1'b0);
    add_text("TOPIC ");
    flush_line(1'b0);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 30 : 0;
      if (ph == 2) hold_wanted = 1'b1;
      queued_count = 0;
      while (queued_count < PHASE_BYTES) add_random_line();
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[irc_line_tokenizer] OK");
    end else begin
      $display("[irc_line_tokenizer] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[irc_line_tokenizer] ERROR");
    $finish;
  end

endmodule
